FILE: design/pmtp_pkg.sv
// Shared constants, codes and types for the permission mask text parser.
package pmtp_pkg;

   localparam int MaskWidth = 9;
   localparam int CharWidth = 8;
   localparam int RspWidth  = 16;

   localparam logic [MaskWidth-1:0] MaskReset = 9'o022;
   localparam logic [MaskWidth-1:0] RBits     = 9'o444;
   localparam logic [MaskWidth-1:0] WBits     = 9'o222;
   localparam logic [MaskWidth-1:0] XBits     = 9'o111;
   localparam logic [MaskWidth-1:0] UBits     = 9'o700;
   localparam logic [MaskWidth-1:0] GBits     = 9'o070;
   localparam logic [MaskWidth-1:0] OBits     = 9'o007;
   localparam logic [MaskWidth-1:0] ABits     = 9'o777;

   localparam logic [CharWidth-1:0] ChEnd   = 8'h00;
   localparam logic [CharWidth-1:0] ChU     = 8'h75;
   localparam logic [CharWidth-1:0] ChG     = 8'h67;
   localparam logic [CharWidth-1:0] ChO     = 8'h6f;
   localparam logic [CharWidth-1:0] ChA     = 8'h61;
   localparam logic [CharWidth-1:0] ChR     = 8'h72;
   localparam logic [CharWidth-1:0] ChW     = 8'h77;
   localparam logic [CharWidth-1:0] ChX     = 8'h78;
   localparam logic [CharWidth-1:0] ChEq    = 8'h3d;
   localparam logic [CharWidth-1:0] ChPlus  = 8'h2b;
   localparam logic [CharWidth-1:0] ChMinus = 8'h2d;
   localparam logic [CharWidth-1:0] ChComma = 8'h2c;
   localparam logic [CharWidth-1:0] ChZero  = 8'h30;
   localparam logic [CharWidth-1:0] ChSeven = 8'h37;

   // Per-character control from the top level to both parsers.
   typedef struct packed {
      logic step;   // consume the character this cycle
      logic start;  // character opens a new string
   } pmtp_ctl_type;

   // Verdict of one parser for the string ending at the current character.
   typedef struct packed {
      logic                 ok;
      logic [MaskWidth-1:0] mask;
   } pmtp_verdict_type;

endpackage

FILE: design/pmtp_octal.sv
// Octal form parser: digit accumulation with range check.
module pmtp_octal (
   input  logic                              clock,
   input  logic                              reset,
   input  pmtp_pkg::pmtp_ctl_type            ctl,
   input  logic [pmtp_pkg::CharWidth-1:0]    character,
   output pmtp_pkg::pmtp_verdict_type        verdict
);
   import pmtp_pkg::*;

   logic [MaskWidth-1:0] value_ff, value_in;
   logic                 failed_ff, failed_in;

   always_comb begin
      logic [MaskWidth-1:0] cur_value;
      logic                 cur_failed;
      cur_value  = ctl.start ? '0 : value_ff;
      cur_failed = ctl.start ? (character == ChEnd) : failed_ff;
      value_in   = cur_value;
      failed_in  = cur_failed;
      if (!cur_failed && character != ChEnd) begin
         if (character < ChZero || character > ChSeven) begin
            failed_in = 1'b1;
         end else if (cur_value[MaskWidth-1 -: 3] != 3'd0) begin
            // another digit would push the value past 0777
            failed_in = 1'b1;
         end else begin
            value_in = {cur_value[MaskWidth-4:0], character[2:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff  <= '0;
         failed_ff <= 1'b0;
      end else if (ctl.step) begin
         value_ff  <= value_in;
         failed_ff <= failed_in;
      end
   end

   assign verdict.ok   = !failed_in;
   assign verdict.mask = value_in;

endmodule

FILE: design/pmtp_symbolic.sv
// Symbolic form parser: who letters, operators and permission letters.
module pmtp_symbolic (
   input  logic                              clock,
   input  logic                              reset,
   input  pmtp_pkg::pmtp_ctl_type            ctl,
   input  logic [pmtp_pkg::CharWidth-1:0]    character,
   input  logic [pmtp_pkg::MaskWidth-1:0]    stored_mask,
   output pmtp_pkg::pmtp_verdict_type        verdict
);
   import pmtp_pkg::*;

   typedef enum logic {PH_WHO, PH_PERM} phase_type;
   typedef enum logic [1:0] {OP_MINUS, OP_PLUS, OP_EQ} oper_type;

   phase_type            phase_ff, phase_in;
   oper_type             oper_ff, oper_in;
   logic [MaskWidth-1:0] target_ff, target_in;
   logic [MaskWidth-1:0] working_ff, working_in;
   logic                 failed_ff, failed_in;

   always_comb begin
      logic                 is_op;
      oper_type             op;
      logic [MaskWidth-1:0] perm;
      logic [MaskWidth-1:0] tgt;
      is_op = 1'b1;
      op    = OP_MINUS;
      tgt   = '0;
      if (character == ChMinus)     op = OP_MINUS;
      else if (character == ChPlus) op = OP_PLUS;
      else if (character == ChEq)   op = OP_EQ;
      else                          is_op = 1'b0;

      perm = '0;
      if (character == ChR)      perm = RBits;
      else if (character == ChW) perm = WBits;
      else if (character == ChX) perm = XBits;

      // open a fresh clause state at string start
      phase_in   = ctl.start ? PH_WHO : phase_ff;
      oper_in    = ctl.start ? OP_MINUS : oper_ff;
      target_in  = ctl.start ? '0 : target_ff;
      working_in = ctl.start ? stored_mask : working_ff;
      failed_in  = ctl.start ? 1'b0 : failed_ff;

      if (!failed_in) begin
         if (phase_in == PH_WHO) begin
            if (character == ChU)      target_in = target_in | UBits;
            else if (character == ChG) target_in = target_in | GBits;
            else if (character == ChO) target_in = target_in | OBits;
            else if (character == ChA) target_in = ABits;
            else if (is_op) begin
               // no who letters means all classes
               tgt       = (target_in == '0) ? ABits : target_in;
               target_in = tgt;
               oper_in   = op;
               phase_in  = PH_PERM;
               if (op == OP_EQ) working_in = working_in | tgt;
            end else begin
               failed_in = 1'b1;
            end
         end else begin
            if (perm != '0) begin
               if (oper_in == OP_MINUS) working_in = working_in | (perm & target_in);
               else                     working_in = working_in & ~(perm & target_in);
            end else if (is_op) begin
               oper_in = op;
               if (op == OP_EQ) working_in = working_in | target_in;
            end else if (character == ChComma) begin
               phase_in  = PH_WHO;
               target_in = '0;
            end else if (character != ChEnd) begin
               failed_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WHO;
         oper_ff    <= OP_MINUS;
         target_ff  <= '0;
         working_ff <= '0;
         failed_ff  <= 1'b0;
      end else if (ctl.step) begin
         phase_ff   <= phase_in;
         oper_ff    <= oper_in;
         target_ff  <= target_in;
         working_ff <= working_in;
         failed_ff  <= failed_in;
      end
   end

   assign verdict.ok   = !failed_in && (phase_in == PH_PERM);
   assign verdict.mask = working_in;

endmodule

FILE: design/permission_mask_text_parser.sv
// Top level of the permission mask text parser: staging, mask store, result.
// A terminator passes through the input register and then the result register to rsp_.
// Throughput: one character per cycle unless a terminator waits; the single parse stage sets the pace.
// A terminator waits in the input register only while an untaken result holds
// the output register; other characters never wait on the result side.
// Reset (synchronous, high): stored mask returns to 022, both stages empty.
module permission_mask_text_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pmtp_pkg::CharWidth-1:0]    req_tdata,  // [7:0] character
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pmtp_pkg::RspWidth-1:0]     rsp_tdata   // [0] accepted,
                                                         // [9:1] mask_value,
                                                         // [10] was_symbolic
);
   import pmtp_pkg::*;

   // input stage
   logic                 in_valid_ff, in_valid_in;
   logic [CharWidth-1:0] char_ff;

   // mask store and string framing
   logic [MaskWidth-1:0] stored_mask_ff, stored_mask_in;
   logic                 at_start_ff, at_start_in;

   // result stage
   logic                 out_valid_ff, out_valid_in;
   logic                 out_accepted_ff, out_accepted_in;
   logic [MaskWidth-1:0] out_mask_ff, out_mask_in;
   logic                 out_symbolic_ff, out_symbolic_in;

   logic             is_end;
   logic             advance;
   pmtp_ctl_type     ctl;
   pmtp_verdict_type oct_verdict;
   pmtp_verdict_type sym_verdict;

   // A terminator needs the result slot; any other character moves freely.
   assign is_end     = (char_ff == ChEnd);
   assign advance    = in_valid_ff && (!is_end || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign ctl.step  = advance;
   assign ctl.start = at_start_ff;

   pmtp_octal u_octal (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .character (char_ff),
      .verdict   (oct_verdict)
   );

   pmtp_symbolic u_symbolic (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .character   (char_ff),
      .stored_mask (stored_mask_ff),
      .verdict     (sym_verdict)
   );

   always_comb begin
      in_valid_in     = req_tready ? req_tvalid : in_valid_ff;
      stored_mask_in  = stored_mask_ff;
      at_start_in     = at_start_ff;
      out_valid_in    = out_valid_ff && !rsp_tready;
      out_accepted_in = out_accepted_ff;
      out_mask_in     = out_mask_ff;
      out_symbolic_in = out_symbolic_ff;
      if (advance) begin
         at_start_in = is_end;
         if (is_end) begin
            out_valid_in = 1'b1;
            // octal wins over symbolic; commit only an accepted string
            priority if (oct_verdict.ok) begin
               stored_mask_in  = oct_verdict.mask;
               out_accepted_in = 1'b1;
               out_symbolic_in = 1'b0;
            end else if (sym_verdict.ok) begin
               stored_mask_in  = sym_verdict.mask;
               out_accepted_in = 1'b1;
               out_symbolic_in = 1'b1;
            end else begin
               out_accepted_in = 1'b0;
               out_symbolic_in = 1'b0;
            end
            out_mask_in = stored_mask_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         stored_mask_ff <= MaskReset;
         at_start_ff    <= 1'b1;
         out_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         stored_mask_ff <= stored_mask_in;
         at_start_ff    <= at_start_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_tready) begin
         char_ff <= req_tdata;
      end
      out_accepted_ff <= out_accepted_in;
      out_mask_ff     <= out_mask_in;
      out_symbolic_ff <= out_symbolic_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspWidth - MaskWidth - 2){1'b0}},
                        out_symbolic_ff, out_mask_ff, out_accepted_ff};

   // A pending result always reports the mask now held in the store.
   a_result_matches_store: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_mask_ff == stored_mask_ff)
      else $error("pending result mask differs from stored mask");

   // Symbolic flag only on an accepted string.
   a_symbolic_implies_accepted: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_symbolic_ff |-> out_accepted_ff)
      else $error("symbolic flag on a rejected string");

   // A consumed terminator opens the next string and produces a result.
   a_terminator_frames: assert property (@(posedge clock) disable iff (reset)
      advance && is_end |=> at_start_ff && out_valid_ff)
      else $error("terminator did not close the string");

   // The store moves only when a terminator is consumed.
   a_store_changes_at_end: assert property (@(posedge clock) disable iff (reset)
      !(advance && is_end) |=> $stable(stored_mask_ff))
      else $error("stored mask changed mid-string");

endmodule
